// ----- design/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the smallest-prime-factor sieve engine.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int VAL_W      = 18;
    localparam int TOT_W      = 5;
    localparam int DIST_W     = 3;
    localparam int PCNT_W     = 15;
    localparam int STAT_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [VAL_W-1:0] LIMIT_RESET = 18'd262143;

    // register index decoded from paddr[CFG_ADDR_W-1]
    localparam logic REG_LIMIT = 1'b0;

    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] STAT_QUERY = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BUILD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [VAL_W-1:0] query_value;
    } spf_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  smallest_factor;
        logic [TOT_W-1:0]  factor_total;
        logic [DIST_W-1:0] distinct_total;
        logic [VAL_W-1:0]  first_prime;
        logic [VAL_W-1:0]  second_prime;
        logic [PCNT_W-1:0] primes_found;
    } spf_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_init;
        logic clr_step;
        logic b_mark;
        logic l_mul;
        logic l_wr;
        logic b_next;
        logic b_fin;
        logic q_init;
        logic q_rd;
        logic q_load_p;
        logic div_start;
        logic q_take;
        logic q_self;
        logic q_rec;
        logic out_bld;
        logic out_err;
        logic out_qry;
    } spf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic lim_small;
        logic clr_last;
        logic j_end;
        logic l_stop;
        logic i_last;
        logic q_bad;
        logic rem_le1;
        logic p_ok;
        logic div_done;
        logic div_zero;
    } spf_stat_t;

endpackage

// ----- design/spf_div.sv -----
// ----------------------------------------------------------------------------
// spf_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_div
    import spf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic             done,
    output logic [VAL_W-1:0] quot,
    output logic [VAL_W-1:0] rmd
);

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [VAL_W-1:0] r_reg;
    logic [VAL_W-1:0] q_reg;
    logic [VAL_W-1:0] d_reg;

    logic [VAL_W:0]   sh;
    logic [VAL_W:0]   diff;
    logic             ge;

    assign sh   = {r_reg, q_reg[VAL_W-1]};
    assign diff = sh - {1'b0, d_reg};
    assign ge   = (sh >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VAL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[VAL_W-1:0] : sh[VAL_W-1:0];
            q_reg <= {q_reg[VAL_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rmd  = r_reg;

endmodule

// ----- design/spf_dpath.sv -----
// ----------------------------------------------------------------------------
// spf_dpath
// Factor table, prime list, sieve counters, query registers and result word.
// ----------------------------------------------------------------------------
module spf_dpath
    import spf_pkg::*;
#(
    parameter int MAX_VALUE   = 262144,
    parameter int PRIME_SLOTS = 32768
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  spf_req_t         req,
    input  logic [VAL_W-1:0] limit,
    input  logic             cfg_wr,
    input  spf_cmd_t         cmd,
    output spf_stat_t        st,
    output spf_rsp_t         rsp
);

    localparam int AW = $clog2(MAX_VALUE);
    localparam int PW = $clog2(PRIME_SLOTS);
    localparam int CW = $clog2(PRIME_SLOTS + 1);

    logic [VAL_W-1:0] tab_mem   [MAX_VALUE];
    logic [VAL_W-1:0] plist_mem [PRIME_SLOTS];

    logic [VAL_W-1:0]   lim;
    logic [VAL_W-1:0]   tab_rd_reg;
    logic [VAL_W-1:0]   plist_rd_reg;
    logic [VAL_W-1:0]   clr_addr_reg;
    logic [VAL_W-1:0]   i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      count_reg;
    logic               built_reg;
    logic [VAL_W-1:0]   sp_reg;
    logic [VAL_W-1:0]   p_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic [VAL_W-1:0]   rem_reg;
    logic [VAL_W-1:0]   pcur_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [DIST_W-1:0]  distinct_reg;
    logic [VAL_W-1:0]   first_reg;
    logic [VAL_W-1:0]   second_reg;
    spf_rsp_t           rsp_reg;
    spf_rsp_t           rsp_next;

    logic               tab_we;
    logic [AW-1:0]      tab_wa;
    logic [VAL_W-1:0]   tab_wd;
    logic [AW-1:0]      tab_ra;
    logic               new_prime;
    logic               list_we;
    logic [VAL_W-1:0]   rec_p;
    logic               div_done;
    logic [VAL_W-1:0]   div_quot;
    logic [VAL_W-1:0]   div_rmd;

    assign lim = (32'(limit) > 32'(MAX_VALUE - 1)) ? VAL_W'(MAX_VALUE - 1) : limit;

    assign new_prime = cmd.b_mark && (tab_rd_reg == '0);
    assign list_we   = new_prime && (count_reg < CW'(PRIME_SLOTS));
    assign tab_ra    = cmd.q_rd ? AW'(rem_reg) : AW'(i_reg);
    assign rec_p     = cmd.q_self ? rem_reg : pcur_reg;

    always_comb
    begin
        tab_we = 1'b0;
        tab_wa = AW'(clr_addr_reg);
        tab_wd = '0;
        priority if (cmd.clr_step)
        begin
            tab_we = 1'b1;
        end
        else if (new_prime)
        begin
            tab_we = 1'b1;
            tab_wa = AW'(i_reg);
            tab_wd = i_reg;
        end
        else if (cmd.l_wr)
        begin
            tab_we = 1'b1;
            tab_wa = AW'(prod_reg);
            tab_wd = p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_wa] <= tab_wd;
        tab_rd_reg <= tab_mem[tab_ra];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            plist_mem[count_reg[PW-1:0]] <= i_reg;
        plist_rd_reg <= plist_mem[j_reg[PW-1:0]];
    end

    // sieve control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            count_reg    <= '0;
            built_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_init)
            begin
                clr_addr_reg <= '0;
                i_reg        <= VAL_W'(2);
                count_reg    <= '0;
            end
            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + VAL_W'(1);
            if (list_we)
                count_reg <= count_reg + CW'(1);
            if (cmd.b_mark)
                j_reg <= '0;
            else if (cmd.l_wr)
                j_reg <= j_reg + CW'(1);
            if (cmd.b_next)
                i_reg <= i_reg + VAL_W'(1);
            if (cfg_wr)
                built_reg <= 1'b0;
            else if (cmd.b_fin)
                built_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.b_mark)
            sp_reg <= new_prime ? i_reg : tab_rd_reg;
        if (cmd.l_mul)
        begin
            p_reg    <= plist_rd_reg;
            prod_reg <= {{VAL_W{1'b0}}, i_reg} * {{VAL_W{1'b0}}, plist_rd_reg};
        end
    end

    // query walk
    always_ff @(posedge clk)
    begin
        if (cmd.q_init)
        begin
            rem_reg      <= req.query_value;
            total_reg    <= '0;
            distinct_reg <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
        end
        if (cmd.q_load_p)
            pcur_reg <= tab_rd_reg;
        if (cmd.q_take)
        begin
            rem_reg   <= div_quot;
            total_reg <= total_reg + TOT_W'(1);
        end
        if (cmd.q_self)
        begin
            rem_reg   <= VAL_W'(1);
            total_reg <= total_reg + TOT_W'(1);
        end
        if (cmd.q_self || cmd.q_rec)
        begin
            if (distinct_reg == DIST_W'(0))
                first_reg <= rec_p;
            else if (distinct_reg == DIST_W'(1))
                second_reg <= rec_p;
            distinct_reg <= distinct_reg + DIST_W'(1);
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.out_bld || cmd.out_err)
        begin
            rsp_next              = '0;
            rsp_next.status       = cmd.out_bld ? STAT_BUILD : STAT_ERROR;
            rsp_next.primes_found = PCNT_W'(count_reg);
        end
        else if (cmd.out_qry)
        begin
            rsp_next.status          = STAT_QUERY;
            rsp_next.smallest_factor = first_reg;
            rsp_next.factor_total    = total_reg;
            rsp_next.distinct_total  = distinct_reg;
            rsp_next.first_prime     = first_reg;
            rsp_next.second_prime    = second_reg;
            rsp_next.primes_found    = PCNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    spf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rem_reg),
        .divisor  (pcur_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rmd      (div_rmd)
    );

    assign st.lim_small = (lim < VAL_W'(2));
    assign st.clr_last  = (clr_addr_reg == lim);
    assign st.j_end     = (j_reg == count_reg);
    assign st.l_stop    = (p_reg > sp_reg) || (prod_reg > {{VAL_W{1'b0}}, lim});
    assign st.i_last    = (i_reg == lim);
    assign st.q_bad     = !built_reg || (req.query_value > lim);
    assign st.rem_le1   = (rem_reg <= VAL_W'(1));
    assign st.p_ok      = (tab_rd_reg >= VAL_W'(2)) && (tab_rd_reg <= rem_reg);
    assign st.div_done  = div_done;
    assign st.div_zero  = (div_rmd == '0);

    assign rsp = rsp_reg;

endmodule

// ----- design/spf_ctrl.sv -----
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer for table clear, linear sieve and factor query.
// ----------------------------------------------------------------------------
module spf_ctrl
    import spf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      req_type,
    input  spf_stat_t st,
    output spf_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLR    = 11'b00000000010,
        S_BRD    = 11'b00000000100,
        S_BMK    = 11'b00000001000,
        S_LRD    = 11'b00000010000,
        S_LMUL   = 11'b00000100000,
        S_LCHK   = 11'b00001000000,
        S_QRD    = 11'b00010000000,
        S_QCHK   = 11'b00100000000,
        S_QSTART = 11'b01000000000,
        S_QDIV   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   done_reg, done_next;
    logic   next_i;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd        = '0;
        next_i     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_BUILD)
                    begin
                        cmd.clr_init = 1'b1;
                        state_next   = S_CLR;
                    end
                    else if (st.q_bad)
                        cmd.out_err = 1'b1;
                    else
                    begin
                        cmd.q_init = 1'b1;
                        state_next = S_QRD;
                    end
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    if (st.lim_small)
                    begin
                        cmd.b_fin   = 1'b1;
                        cmd.out_bld = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                        state_next = S_BRD;
                end
            end
            S_BRD:
                state_next = S_BMK;
            S_BMK:
            begin
                cmd.b_mark = 1'b1;
                state_next = S_LRD;
            end
            S_LRD:
            begin
                if (st.j_end)
                    next_i = 1'b1;
                else
                    state_next = S_LMUL;
            end
            S_LMUL:
            begin
                cmd.l_mul  = 1'b1;
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                if (st.l_stop)
                    next_i = 1'b1;
                else
                begin
                    cmd.l_wr   = 1'b1;
                    state_next = S_LRD;
                end
            end
            S_QRD:
            begin
                if (st.rem_le1)
                begin
                    cmd.out_qry = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_QCHK;
                end
            end
            S_QCHK:
            begin
                if (st.p_ok)
                begin
                    cmd.q_load_p = 1'b1;
                    first_next   = 1'b1;
                    state_next   = S_QSTART;
                end
                else
                begin
                    // unusable entry: the remainder itself is the prime
                    cmd.q_self = 1'b1;
                    state_next = S_QRD;
                end
            end
            S_QSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_QDIV;
            end
            S_QDIV:
            begin
                if (st.div_done)
                begin
                    if (st.div_zero)
                    begin
                        cmd.q_take = 1'b1;
                        first_next = 1'b0;
                        state_next = S_QSTART;
                    end
                    else
                    begin
                        cmd.q_self = first_reg;
                        cmd.q_rec  = !first_reg;
                        state_next = S_QRD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (next_i)
        begin
            if (st.i_last)
            begin
                cmd.b_fin   = 1'b1;
                cmd.out_bld = 1'b1;
                state_next  = S_IDLE;
            end
            else
            begin
                cmd.b_next = 1'b1;
                state_next = S_BRD;
            end
        end
    end

    assign done_next = cmd.out_bld || cmd.out_err || cmd.out_qry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_build_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_BUILD) |=> state_reg == S_CLR)
        else $error("build request did not enter table clear");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDIV) && !st.div_done |=> state_reg == S_QDIV)
        else $error("left division wait before divider finished");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result word with no request in progress");

endmodule

// ----- design/spf_sieve_factor_engine.sv -----
// ----------------------------------------------------------------------------
// spf_sieve_factor_engine
// Linear-sieve smallest-prime-factor table with a factor query, APB config.
// ----------------------------------------------------------------------------
// Query: an error is answered straight from idle; else each step is a table
//   lookup followed by trial divisions on the bit-serial divider.
// Build: clears entries 0 to L, then visits each value and marks its multiples
//   by listed primes until the walk stops on a bound; L is the effective limit.
// One word at a time; done pulses one cycle, the receiver cannot stall.
// Reset clears control, counts and the built flag; tables are cleared by build.
module spf_sieve_factor_engine
    import spf_pkg::*;
#(
    parameter int MAX_VALUE   = 262144,
    parameter int PRIME_SLOTS = 32768
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  spf_req_t              req,
    output logic                  done,
    output spf_rsp_t              rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [VAL_W-1:0] limit_reg;
    logic             cfg_wr;
    spf_cmd_t         cmd;
    spf_stat_t        st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr)
            limit_reg <= pwdata[VAL_W-1:0];
    end

    assign prdata = (paddr[CFG_ADDR_W-1] == REG_LIMIT) ? CFG_DATA_W'(limit_reg) : '0;

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    spf_dpath #(
        .MAX_VALUE   (MAX_VALUE),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .limit  (limit_reg),
        .cfg_wr (cfg_wr),
        .cmd    (cmd),
        .st     (st),
        .rsp    (rsp)
    );

endmodule
